// ----- src/psl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psl_pkg
// Shared widths, register indexes, mode codes and the captured sample type
// for the portamento slew limiter.
// ----------------------------------------------------------------------------
package psl_pkg;

    // port formats
    localparam int PORT_W         = 21;
    localparam int PORT_FRAC_DEF  = 16;
    localparam int INNER_FRAC_DEF = 32;

    // knob amounts and step sizes
    localparam int AMT_W     = 17;
    localparam int FS_W      = 19;
    localparam int STEP_BITS = 40;
    localparam int DEN_W     = 58;
    localparam int TIMER_W   = 16;
    localparam logic [AMT_W-1:0] KNOB_ONE = 17'd65536;
    localparam logic [AMT_W-1:0] VAL_MAX  = 17'd131071;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_AMOUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_AMOUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_MODE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINK        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_GLIDE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd6;

    // glide modes
    localparam logic [1:0] MODE_FAST = 2'd0;
    localparam logic [1:0] MODE_SLOW = 2'd1;
    localparam logic [1:0] MODE_TIME = 2'd2;
    localparam logic [1:0] MODE_HOLD = 2'd3;

    // one captured input request
    typedef struct packed {
        logic signed [PORT_W-1:0] in_value;
        logic                     in_connected;
        logic signed [PORT_W-1:0] gate_value;
        logic                     gate_connected;
        logic signed [PORT_W-1:0] clock_value;
        logic                     clock_connected;
        logic signed [PORT_W-1:0] rise_cv;
        logic                     rise_cv_connected;
        logic signed [PORT_W-1:0] fall_cv;
        logic                     fall_cv_connected;
        logic                     trig_outputs_used;
    } sample_t;

endpackage
`default_nettype wire

// ----- src/psl_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psl_if
// Channel interfaces: sample requests, result requests, register writes.
// ----------------------------------------------------------------------------
interface psl_sample_if;
    import psl_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [PORT_W-1:0] in_value;
    logic                     in_connected;
    logic signed [PORT_W-1:0] gate_value;
    logic                     gate_connected;
    logic signed [PORT_W-1:0] clock_value;
    logic                     clock_connected;
    logic signed [PORT_W-1:0] rise_cv;
    logic                     rise_cv_connected;
    logic signed [PORT_W-1:0] fall_cv;
    logic                     fall_cv_connected;
    logic                     trig_outputs_used;

    modport source (output valid, in_value, in_connected, gate_value, gate_connected,
                    clock_value, clock_connected, rise_cv, rise_cv_connected,
                    fall_cv, fall_cv_connected, trig_outputs_used, input ready);
    modport sink (input valid, in_value, in_connected, gate_value, gate_connected,
                  clock_value, clock_connected, rise_cv, rise_cv_connected,
                  fall_cv, fall_cv_connected, trig_outputs_used, output ready);
endinterface

interface psl_result_if;
    import psl_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [PORT_W-1:0] out_value;
    logic                     rising;
    logic                     falling;
    logic                     rise_done_pulse;
    logic                     fall_done_pulse;
    logic                     any_done_pulse;

    modport source (output valid, out_value, rising, falling, rise_done_pulse,
                    fall_done_pulse, any_done_pulse, input ready);
    modport sink (input valid, out_value, rising, falling, rise_done_pulse,
                  fall_done_pulse, any_done_pulse, output ready);
endinterface

interface psl_cfg_if;
    import psl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- src/psl_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// psl_divider
// Restoring divider, one numerator bit per cycle. Quotient saturates at
// all ones when it does not fit in Q_W bits.
// ----------------------------------------------------------------------------
module psl_divider #(
    parameter int NUM_W = 69,
    parameter int DEN_W = 58,
    parameter int Q_W   = 40
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [Q_W-1:0]        quot
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic             sat_reg, sat_next;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    // one trial subtraction a cycle
    always_comb
    begin
        rem_sh    = {rem_reg, num_reg[NUM_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            sat_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
            q_next   = {q_reg[Q_W-2:0], ge};
            num_next = {num_reg[NUM_W-2:0], 1'b0};
            if (ge && (int'(cnt_reg) >= Q_W))
                sat_next = 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done = done_reg;
    assign quot = sat_reg ? {Q_W{1'b1}} : q_reg;

endmodule
`default_nettype wire

// ----- src/portamento_slew_limiter_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// portamento_slew_limiter_top
// One channel of a portamento slew limiter, one audio sample per request.
// ----------------------------------------------------------------------------
// Usage:
//  sample_ch carries one audio sample request: input, gate, clock and the
//  rise/fall control voltages with their jack-connected bits. result_ch
//  returns one result request per sample: glided output, rising/falling
//  flags and the end-of-glide trigger pulses. cfg_ch writes the seven
//  registers (index 0..6, others ignored); it is always ready and should be
//  written only while no sample is in flight.
//  A sample request steps through the sequencer from acceptance to its
//  result; a recomputed step size adds a run of the shared restoring
//  divider over NUM_W numerator bits (NUM_W = 53 + INNER - PORT_FRAC, 69
//  by default), one quotient bit per cycle. sample_ch.ready is high only
//  while the sequencer is idle, so a new sample is accepted only once the
//  last one has loaded its result.
//  A result waits in the output register while the receiver stalls; the
//  next sample is accepted and worked on meanwhile, holding only at the
//  point of loading its own result.
//  Reset clears control state and loads register defaults; payload is not reset.
// ----------------------------------------------------------------------------
module portamento_slew_limiter_top #(
    parameter int PORT_FRAC_BITS  = psl_pkg::PORT_FRAC_DEF,
    parameter int INNER_FRAC_BITS = psl_pkg::INNER_FRAC_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    psl_cfg_if.sink       cfg_ch,
    psl_sample_if.sink    sample_ch,
    psl_result_if.source  result_ch
);
    import psl_pkg::*;

    localparam int SH     = INNER_FRAC_BITS - PORT_FRAC_BITS;
    localparam int V_W    = PORT_W + SH;
    localparam int SUM_W  = ((V_W > STEP_BITS) ? V_W : STEP_BITS) + 2;
    localparam int NUM_W  = V_W + 32;
    localparam int PROD_W = PORT_W + AMT_W + 1;
    localparam int P1_W   = AMT_W + FS_W;
    localparam int P2_W   = P1_W + AMT_W;

    localparam longint unsigned INNER_ONE = 64'd1 << INNER_FRAC_BITS;
    localparam longint unsigned THRESH    = INNER_ONE / 100;
    localparam longint unsigned MIN_STEP  = (INNER_ONE + 500000) / 1000000;
    localparam int PORT_ONE   = 1 << PORT_FRAC_BITS;
    localparam int GATE_LOW   = PORT_ONE / 2;
    localparam int CLOCK_HIGH = (PORT_ONE * 5) / 2;
    localparam int CLOCK_LOW  = (PORT_ONE + 99) / 100;

    localparam logic [NUM_W-1:0] FAST_NUM = NUM_W'(200) << (INNER_FRAC_BITS + 16);
    localparam logic [NUM_W-1:0] SLOW_NUM = NUM_W'(1) << (INNER_FRAC_BITS + 16);
    // reciprocal multipliers: x / 10 = (x * DIV10_MUL) >> 35 for any 32-bit x,
    // x / 1000 = (x * DIV1000_MUL) >> 38 for any 32-bit x
    localparam logic [31:0] DIV10_MUL   = 32'hCCCCCCCD;
    localparam logic [31:0] DIV1000_MUL = 32'h10624DD3;

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_PREP      = 4'd1;
    localparam logic [3:0] S_EFF_MUL   = 4'd2;
    localparam logic [3:0] S_EFF_SCALE = 4'd3;
    localparam logic [3:0] S_VCHK      = 4'd4;
    localparam logic [3:0] S_DEN1      = 4'd5;
    localparam logic [3:0] S_DEN2      = 4'd6;
    localparam logic [3:0] S_DEN3      = 4'd7;
    localparam logic [3:0] S_STEP_GO   = 4'd8;
    localparam logic [3:0] S_STEP_WAIT = 4'd9;
    localparam logic [3:0] S_APPLY     = 4'd10;
    localparam logic [3:0] S_TRIG      = 4'd11;
    localparam logic [3:0] S_LEN       = 4'd12;
    localparam logic [3:0] S_FINISH    = 4'd13;

    // configuration registers
    logic [AMT_W-1:0] rise_amt_reg, fall_amt_reg;
    logic [1:0]       rise_mode_reg, fall_mode_reg;
    logic             link_reg, sg_reg;
    logic [FS_W-1:0]  fs_reg;

    // control and glide state
    logic [3:0]              state_reg, state_next;
    sample_t                 smp_reg, smp_next;
    logic signed [V_W-1:0]   held_reg, held_next, glide_reg, glide_next;
    logic                    ntf_reg, ntf_next, grel_reg, grel_next;
    logic                    rising_reg, rising_next, falling_reg, falling_next;
    logic                    rend_reg, rend_next, fend_reg, fend_next;
    logic [3:0]              gcnt_reg, gcnt_next;
    logic [STEP_BITS-1:0]    rstep_reg, rstep_next, fstep_reg, fstep_next;
    logic [AMT_W-1:0]        lastr_reg, lastr_next, lastf_reg, lastf_next;
    logic [AMT_W-1:0]        prevr_reg, prevr_next, prevf_reg, prevf_next;
    logic [TIMER_W-1:0]      rtim_reg, rtim_next, ftim_reg, ftim_next;
    logic [PORT_W-1:0]       repv_reg, repv_next;
    logic                    reppr_reg, reppr_next, reppf_reg, reppf_next;
    logic                    repany_reg, repany_next;
    logic                    disc_reg, disc_next, up_reg, up_next;
    logic [1:0]              mode_reg, mode_next;
    logic [AMT_W-1:0]        v_reg, v_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [P1_W-1:0]         p1_reg, p1_next;
    logic [P2_W-1:0]         p2_reg, p2_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [TIMER_W-1:0]      len_reg, len_next;

    // output register
    logic                    ov_reg, ov_next;
    logic [PORT_W-1:0]       oval_reg, oval_next;
    logic                    orise_reg, orise_next, ofall_reg, ofall_next;
    logic                    opr_reg, opr_next, opf_reg, opf_next, oany_reg, oany_next;

    // divider hookup
    logic                 div_start;
    logic [NUM_W-1:0]     div_num;
    logic [DEN_W-1:0]     div_den;
    logic                 div_done;
    logic [STEP_BITS-1:0] div_q;

    psl_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(STEP_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // helper terms
    logic [FS_W-1:0]         fs_eff;
    logic [AMT_W-1:0]        amt_sel, amt_sat;
    logic signed [V_W-1:0]   inv_c, held_c, glide_c;
    logic signed [V_W:0]     tdiff;
    logic [V_W:0]            tabs;
    logic signed [31:0]      gate_w, clk_w;
    logic                    ntf_c, allow_c, glide_en;
    logic [V_W-1:0]          dist_c;
    logic [STEP_BITS-1:0]    step_c;
    logic signed [SUM_W-1:0] g_ext, h_ext, s_ext, sum_c;
    logic [TIMER_W-1:0]      rt_c, ft_c;
    logic                    pr_c, pf_c;
    logic [PROD_W-2:0]       cv_y;
    logic [63:0]             cv_prod;
    logic [28:0]             cv_q;
    logic [47:0]             len_prod;
    logic [9:0]              len_q;

    assign fs_eff  = (fs_reg == '0) ? FS_W'(1) : fs_reg;
    assign amt_sel = up_reg ? rise_amt_reg : fall_amt_reg;
    assign amt_sat = (amt_sel > KNOB_ONE) ? KNOB_ONE : amt_sel;
    assign inv_c   = V_W'(smp_reg.in_value) <<< SH;
    assign gate_w  = 32'(smp_reg.gate_value);
    assign clk_w   = 32'(smp_reg.clock_value);
    assign tdiff   = (V_W+1)'(held_reg) - (V_W+1)'(inv_c);
    assign tabs    = tdiff[V_W] ? (V_W+1)'(-tdiff) : (V_W+1)'(tdiff);
    assign ntf_c   = ntf_reg || (tabs > (V_W+1)'(THRESH));
    assign dist_c  = up_reg ? V_W'(held_reg - glide_reg) : V_W'(glide_reg - held_reg);
    assign step_c  = up_reg ? rstep_reg : fstep_reg;
    assign g_ext   = SUM_W'(glide_reg);
    assign h_ext   = SUM_W'(held_reg);
    assign s_ext   = $signed({{(SUM_W-STEP_BITS){1'b0}}, step_c});
    assign sum_c   = up_reg ? (g_ext + s_ext) : (g_ext - s_ext);

    // control voltage scaling: product / (10 * 2^PORT_FRAC), product not negative
    assign cv_y     = prod_reg[PROD_W-2:0] >> PORT_FRAC_BITS;
    assign cv_prod  = 64'(cv_y[31:0]) * 64'(DIV10_MUL);
    assign cv_q     = cv_prod[63:35];

    // pulse length: sample rate / 1000
    assign len_prod = 48'(fs_eff) * 48'(DIV1000_MUL);
    assign len_q    = len_prod[47:38];

    // divider operands for the step size
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (state_reg)
            S_STEP_GO:
            begin
                div_start = 1'b1;
                div_den   = den_reg;
                case (mode_reg)
                    MODE_FAST: div_num = FAST_NUM;
                    MODE_SLOW: div_num = SLOW_NUM;
                    default:   div_num = {dist_c, 32'd0};
                endcase
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;  smp_next = smp_reg;
        held_next = held_reg;    glide_next = glide_reg;
        ntf_next = ntf_reg;      grel_next = grel_reg;
        rising_next = rising_reg; falling_next = falling_reg;
        rend_next = rend_reg;    fend_next = fend_reg;
        gcnt_next = gcnt_reg;
        rstep_next = rstep_reg;  fstep_next = fstep_reg;
        lastr_next = lastr_reg;  lastf_next = lastf_reg;
        prevr_next = prevr_reg;  prevf_next = prevf_reg;
        rtim_next = rtim_reg;    ftim_next = ftim_reg;
        repv_next = repv_reg;    reppr_next = reppr_reg;
        reppf_next = reppf_reg;  repany_next = repany_reg;
        disc_next = disc_reg;    up_next = up_reg;
        mode_next = mode_reg;    v_next = v_reg;
        prod_next = prod_reg;    p1_next = p1_reg;
        p2_next = p2_reg;        den_next = den_reg;
        len_next = len_reg;
        ov_next = ov_reg;        oval_next = oval_reg;
        orise_next = orise_reg;  ofall_next = ofall_reg;
        opr_next = opr_reg;      opf_next = opf_reg;
        oany_next = oany_reg;
        held_c = held_reg;       glide_c = glide_reg;
        allow_c = 1'b0;          glide_en = 1'b0;
        rt_c = rtim_reg;         ft_c = ftim_reg;
        pr_c = 1'b0;             pf_c = 1'b0;

        if (result_ch.ready)
            ov_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_ch.valid)
                begin
                    smp_next.in_value          = sample_ch.in_value;
                    smp_next.in_connected      = sample_ch.in_connected;
                    smp_next.gate_value        = sample_ch.gate_value;
                    smp_next.gate_connected    = sample_ch.gate_connected;
                    smp_next.clock_value       = sample_ch.clock_value;
                    smp_next.clock_connected   = sample_ch.clock_connected;
                    smp_next.rise_cv           = sample_ch.rise_cv;
                    smp_next.rise_cv_connected = sample_ch.rise_cv_connected;
                    smp_next.fall_cv           = sample_ch.fall_cv;
                    smp_next.fall_cv_connected = sample_ch.fall_cv_connected;
                    smp_next.trig_outputs_used = sample_ch.trig_outputs_used;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                disc_next = !smp_reg.in_connected;
                if (!smp_reg.in_connected)
                begin
                    // unplugged input clears target, output and gate flag
                    held_next  = '0;
                    glide_next = '0;
                    grel_next  = 1'b0;
                    state_next = S_FINISH;
                end
                else
                begin
                    ntf_next = ntf_c;
                    // target latch
                    if (sg_reg)
                    begin
                        if (smp_reg.clock_connected)
                        begin
                            if (gcnt_reg > 4'd8 && clk_w > CLOCK_HIGH)
                            begin
                                allow_c   = 1'b1;
                                held_c    = inv_c;
                                gcnt_next = '0;
                            end
                            else if (gcnt_reg < 4'd10 && clk_w < CLOCK_LOW)
                                gcnt_next = gcnt_reg + 4'd1;
                        end
                        else
                            allow_c = !rising_reg && !falling_reg;
                        if (allow_c && ntf_c)
                            held_c = inv_c;
                    end
                    else if (ntf_c)
                        held_c = inv_c;
                    // gate
                    if (smp_reg.gate_connected)
                    begin
                        if (gate_w < GATE_LOW)
                        begin
                            grel_next = 1'b1;
                            glide_c   = held_c;
                        end
                        else if (grel_reg)
                        begin
                            glide_c   = held_c;
                            grel_next = 1'b0;
                        end
                        else
                            glide_en = 1'b1;
                    end
                    else
                        glide_en = 1'b1;
                    held_next  = held_c;
                    glide_next = glide_c;
                    up_next    = held_c > glide_c;
                    if (glide_en && held_c != glide_c)
                    begin
                        if (held_c > glide_c)
                        begin
                            mode_next = rise_mode_reg;
                            if (smp_reg.rise_cv_connected)
                                state_next = S_EFF_MUL;
                            else
                            begin
                                v_next = (rise_amt_reg > KNOB_ONE) ? KNOB_ONE : rise_amt_reg;
                                state_next = S_VCHK;
                            end
                        end
                        else if (link_reg)
                        begin
                            mode_next  = rise_mode_reg;
                            v_next     = lastr_reg;
                            state_next = S_VCHK;
                        end
                        else
                        begin
                            mode_next = fall_mode_reg;
                            if (smp_reg.fall_cv_connected)
                                state_next = S_EFF_MUL;
                            else
                            begin
                                v_next = (fall_amt_reg > KNOB_ONE) ? KNOB_ONE : fall_amt_reg;
                                state_next = S_VCHK;
                            end
                        end
                    end
                    else
                    begin
                        rising_next  = 1'b0;
                        falling_next = 1'b0;
                        glide_next   = held_c;
                        state_next   = S_TRIG;
                    end
                end
            end
            S_EFF_MUL:
            begin
                prod_next = (up_reg ? smp_reg.rise_cv : smp_reg.fall_cv)
                            * $signed({1'b0, amt_sat});
                state_next = S_EFF_SCALE;
            end
            S_EFF_SCALE:
            begin
                // a negative product counts as zero
                if (prod_reg[PROD_W-1])
                    v_next = '0;
                else
                    v_next = (cv_q > 29'(VAL_MAX)) ? VAL_MAX : cv_q[AMT_W-1:0];
                state_next = S_VCHK;
            end
            S_VCHK:
            begin
                if (up_reg)
                    lastr_next = v_reg;
                else
                    lastf_next = v_reg;
                if (v_reg == '0)
                begin
                    // zero amount jumps straight to the target
                    glide_next = held_reg;
                    if (up_reg)
                    begin
                        rising_next = 1'b0;
                        rend_next   = 1'b1;
                    end
                    else
                    begin
                        falling_next = 1'b0;
                        fend_next    = 1'b1;
                    end
                    state_next = S_TRIG;
                end
                else
                begin
                    case (mode_reg)
                        MODE_FAST, MODE_SLOW: state_next = S_DEN1;
                        MODE_TIME:
                        begin
                            if (ntf_reg || v_reg != (up_reg ? prevr_reg : prevf_reg))
                            begin
                                if (up_reg)
                                    prevr_next = v_reg;
                                else
                                    prevf_next = v_reg;
                                ntf_next   = 1'b0;
                                state_next = S_DEN1;
                            end
                            else
                                state_next = S_APPLY;
                        end
                        default: state_next = S_APPLY;
                    endcase
                end
            end
            S_DEN1:
            begin
                p1_next    = P1_W'(v_reg) * P1_W'(fs_eff);
                state_next = S_DEN2;
            end
            S_DEN2:
            begin
                p2_next    = P2_W'(p1_reg) * P2_W'(v_reg);
                state_next = S_DEN3;
            end
            S_DEN3:
            begin
                case (mode_reg)
                    MODE_FAST: den_next = DEN_W'(200 * 65536) + DEN_W'(p1_reg);
                    MODE_SLOW: den_next = DEN_W'(65536) + (DEN_W'(p1_reg) << 1);
                    default:   den_next = (DEN_W'(p2_reg) << 3) + (DEN_W'(p2_reg) << 1);
                endcase
                state_next = S_STEP_GO;
            end
            S_STEP_GO:
            begin
                state_next = S_STEP_WAIT;
            end
            S_STEP_WAIT:
            begin
                if (div_done)
                begin
                    if (up_reg)
                        rstep_next = div_q;
                    else
                        fstep_next = div_q;
                    if (mode_reg == MODE_TIME && div_q < STEP_BITS'(MIN_STEP))
                    begin
                        if (up_reg)
                            rstep_next = STEP_BITS'(MIN_STEP);
                        else
                            fstep_next = STEP_BITS'(MIN_STEP);
                    end
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (up_reg)
                begin
                    falling_next = 1'b0;
                    if (sum_c >= h_ext)
                    begin
                        glide_next  = held_reg;
                        rising_next = 1'b0;
                        rend_next   = 1'b1;
                    end
                    else
                    begin
                        glide_next  = V_W'(sum_c);
                        rising_next = 1'b1;
                    end
                end
                else
                begin
                    rising_next = 1'b0;
                    if (sum_c <= h_ext)
                    begin
                        glide_next   = held_reg;
                        falling_next = 1'b0;
                        fend_next    = 1'b1;
                    end
                    else
                    begin
                        glide_next   = V_W'(sum_c);
                        falling_next = 1'b1;
                    end
                end
                state_next = S_TRIG;
            end
            S_TRIG:
            begin
                if (smp_reg.trig_outputs_used && (rend_reg || fend_reg))
                    state_next = S_LEN;
                else
                    state_next = S_FINISH;
            end
            S_LEN:
            begin
                len_next   = (len_q == '0) ? TIMER_W'(1) : TIMER_W'(len_q);
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!ov_reg || result_ch.ready)
                begin
                    ov_next = 1'b1;
                    if (disc_reg)
                    begin
                        oval_next  = repv_reg;
                        orise_next = 1'b0;
                        ofall_next = 1'b0;
                        opr_next   = reppr_reg;
                        opf_next   = reppf_reg;
                        oany_next  = repany_reg;
                    end
                    else
                    begin
                        repv_next = glide_reg[V_W-1:SH];
                        oval_next = glide_reg[V_W-1:SH];
                        orise_next = rising_reg;
                        ofall_next = falling_reg;
                        opr_next   = reppr_reg;
                        opf_next   = reppf_reg;
                        oany_next  = repany_reg;
                        if (smp_reg.trig_outputs_used)
                        begin
                            // pulse timers restart on a fresh end
                            if (rend_reg)
                                rt_c = len_reg;
                            if (fend_reg)
                                ft_c = len_reg;
                            rend_next   = 1'b0;
                            fend_next   = 1'b0;
                            pr_c        = rt_c != '0;
                            pf_c        = ft_c != '0;
                            rtim_next   = rt_c - TIMER_W'(pr_c);
                            ftim_next   = ft_c - TIMER_W'(pf_c);
                            reppr_next  = pr_c;
                            reppf_next  = pf_c;
                            repany_next = pr_c || pf_c;
                            opr_next    = pr_c;
                            opf_next    = pf_c;
                            oany_next   = pr_c || pf_c;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg <= '0;    glide_reg <= '0;
            ntf_reg <= 1'b0;   grel_reg <= 1'b0;
            rising_reg <= 1'b0; falling_reg <= 1'b0;
            rend_reg <= 1'b0;  fend_reg <= 1'b0;
            gcnt_reg <= '0;
            rstep_reg <= '0;   fstep_reg <= '0;
            lastr_reg <= '0;   lastf_reg <= '0;
            prevr_reg <= '0;   prevf_reg <= '0;
            rtim_reg <= '0;    ftim_reg <= '0;
            repv_reg <= '0;    reppr_reg <= 1'b0;
            reppf_reg <= 1'b0; repany_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg <= held_next;    glide_reg <= glide_next;
            ntf_reg <= ntf_next;      grel_reg <= grel_next;
            rising_reg <= rising_next; falling_reg <= falling_next;
            rend_reg <= rend_next;    fend_reg <= fend_next;
            gcnt_reg <= gcnt_next;
            rstep_reg <= rstep_next;  fstep_reg <= fstep_next;
            lastr_reg <= lastr_next;  lastf_reg <= lastf_next;
            prevr_reg <= prevr_next;  prevf_reg <= prevf_next;
            rtim_reg <= rtim_next;    ftim_reg <= ftim_next;
            repv_reg <= repv_next;    reppr_reg <= reppr_next;
            reppf_reg <= reppf_next;  repany_reg <= repany_next;
            ov_reg <= ov_next;
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
        disc_reg <= disc_next;  up_reg <= up_next;
        mode_reg <= mode_next;  v_reg <= v_next;
        prod_reg <= prod_next;  p1_reg <= p1_next;
        p2_reg <= p2_next;      den_reg <= den_next;
        len_reg <= len_next;
        oval_reg <= oval_next;  orise_reg <= orise_next;
        ofall_reg <= ofall_next; opr_reg <= opr_next;
        opf_reg <= opf_next;    oany_reg <= oany_next;
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_amt_reg  <= '0;
            fall_amt_reg  <= '0;
            rise_mode_reg <= MODE_TIME;
            fall_mode_reg <= MODE_TIME;
            link_reg      <= 1'b1;
            sg_reg        <= 1'b0;
            fs_reg        <= FS_W'(44100);
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                REG_RISE_AMOUNT:  rise_amt_reg  <= cfg_ch.data[AMT_W-1:0];
                REG_FALL_AMOUNT:  fall_amt_reg  <= cfg_ch.data[AMT_W-1:0];
                REG_RISE_MODE:    rise_mode_reg <= cfg_ch.data[1:0];
                REG_FALL_MODE:    fall_mode_reg <= cfg_ch.data[1:0];
                REG_LINK:         link_reg      <= cfg_ch.data[0];
                REG_SAMPLE_GLIDE: sg_reg        <= cfg_ch.data[0];
                REG_SAMPLE_RATE:  fs_reg        <= cfg_ch.data[FS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg_ch.ready              = 1'b1;
    assign sample_ch.ready           = (state_reg == S_IDLE);
    assign result_ch.valid           = ov_reg;
    assign result_ch.out_value       = oval_reg;
    assign result_ch.rising          = orise_reg;
    assign result_ch.falling         = ofall_reg;
    assign result_ch.rise_done_pulse = opr_reg;
    assign result_ch.fall_done_pulse = opf_reg;
    assign result_ch.any_done_pulse  = oany_reg;

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
        else $error("sample accepted while a sample is in flight");

    a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
        !(rising_reg && falling_reg))
        else $error("rising and falling set together");

    a_any_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.any_done_pulse ==
            (result_ch.rise_done_pulse || result_ch.fall_done_pulse)))
        else $error("any pulse differs from rise/fall pulses");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_STEP_WAIT))
        else $error("divider finished outside the step wait state");

endmodule
`default_nettype wire
